/* rtl/wsfd_pkg.sv */
// Shared types and codes for the WebSocket frame deframer.
// No dependencies; imported by wsfd_parser, websocket_frame_deframer_unit, wsfd_result_checker and the testbench.
`default_nettype none

package wsfd_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   // Header constants
   localparam logic [7:0] MASK_BIT      = 8'h80;
   localparam logic [7:0] LEN7_MASK     = 8'h7F;
   localparam logic [6:0] LEN7_EXT16    = 7'd126;
   localparam logic [6:0] LEN7_EXT64    = 7'd127;
   localparam logic [2:0] EXT16_LAST    = 3'd1;
   localparam logic [2:0] EXT64_LAST    = 3'd7;
   localparam logic [2:0] KEY_LAST      = 3'd3;

   // One result word from the parser to the output register
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
      status_type status;
   } wsfd_result_type;

endpackage

`default_nettype wire

/* rtl/wsfd_parser.sv */
// Frame parser: holds the header/payload state and turns one byte into
// at most one result word. Depends on wsfd_pkg.
`default_nettype none

module wsfd_parser
   import wsfd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire logic [7:0]      data_byte,
   input  wire logic            end_of_frame,
   output wsfd_result_type      result
);

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_LEN     = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_DROP    = 3'd6
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic        mask_ff, mask_in;
   logic [31:0] key_ff, key_in;
   logic [63:0] remain_ff, remain_in;
   logic [1:0]  kpos_ff, kpos_in;

   logic        len_done;
   logic        pay_begin;
   logic [6:0]  len7;
   logic [7:0]  key_byte;
   logic [63:0] remain_dec;

   // Key byte for the current payload index, first key byte in bits 31..24
   always_comb begin
      case (kpos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign len7       = data_byte[6:0] & LEN7_MASK[6:0];
   assign remain_dec = remain_ff - 64'd1;

   // Next state and result for one byte
   always_comb begin
      phase_in      = phase_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      key_in        = key_ff;
      remain_in     = remain_ff;
      kpos_in       = kpos_ff;
      len_done      = 1'b0;
      pay_begin     = 1'b0;
      result.valid  = 1'b0;
      result.data   = 8'd0;
      result.last   = 1'b0;
      result.status = ST_DATA;

      case (phase_ff)
         PH_LEN: begin
            mask_in   = (data_byte & MASK_BIT) != 8'd0;
            remain_in = 64'd0;
            count_in  = 3'd0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
               if (end_of_frame) begin
                  phase_in      = PH_FIRST;
                  result.valid  = 1'b1;
                  result.last   = 1'b1;
                  result.status = ST_ERROR;
               end else begin
                  phase_in = (len7 == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
               end
            end else begin
               remain_in = {57'd0, len7};
               len_done  = 1'b1;
            end
         end
         PH_EXT16, PH_EXT64: begin
            remain_in = {remain_ff[55:0], data_byte};
            if (count_ff == ((phase_ff == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) begin
               len_done = 1'b1;
            end else begin
               count_in = count_ff + 3'd1;
               if (end_of_frame) begin
                  phase_in      = PH_FIRST;
                  result.valid  = 1'b1;
                  result.last   = 1'b1;
                  result.status = ST_ERROR;
               end
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], data_byte};
            if (count_ff == KEY_LAST) begin
               pay_begin = 1'b1;
            end else begin
               count_in = count_ff + 3'd1;
               if (end_of_frame) begin
                  phase_in      = PH_FIRST;
                  result.valid  = 1'b1;
                  result.last   = 1'b1;
                  result.status = ST_ERROR;
               end
            end
         end
         PH_PAYLOAD: begin
            kpos_in   = kpos_ff + 2'd1;
            remain_in = remain_dec;
            result.valid = 1'b1;
            if (remain_dec == 64'd0) begin
               phase_in    = end_of_frame ? PH_FIRST : PH_DROP;
               result.data = data_byte ^ (mask_ff ? key_byte : 8'd0);
               result.last = 1'b1;
            end else if (end_of_frame) begin
               phase_in      = PH_FIRST;
               result.last   = 1'b1;
               result.status = ST_ERROR;
            end else begin
               result.data = data_byte ^ (mask_ff ? key_byte : 8'd0);
            end
         end
         PH_DROP: begin
            if (end_of_frame) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            // first header byte, or unused phase code
            if (end_of_frame) begin
               phase_in      = PH_FIRST;
               result.valid  = 1'b1;
               result.last   = 1'b1;
               result.status = ST_ERROR;
            end else begin
               phase_in = PH_LEN;
            end
         end
      endcase

      // Length known: key next if masked, else start payload
      if (len_done) begin
         if (mask_in) begin
            if (end_of_frame) begin
               phase_in      = PH_FIRST;
               result.valid  = 1'b1;
               result.last   = 1'b1;
               result.status = ST_ERROR;
            end else begin
               phase_in = PH_KEY;
               count_in = 3'd0;
               key_in   = 32'd0;
            end
         end else begin
            pay_begin = 1'b1;
         end
      end

      // Header complete: empty payload, early end, or payload
      if (pay_begin) begin
         kpos_in = 2'd0;
         if (remain_in == 64'd0) begin
            phase_in      = end_of_frame ? PH_FIRST : PH_DROP;
            result.valid  = 1'b1;
            result.last   = 1'b1;
            result.status = ST_EMPTY;
         end else if (end_of_frame) begin
            phase_in      = PH_FIRST;
            result.valid  = 1'b1;
            result.last   = 1'b1;
            result.status = ST_ERROR;
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   // State registers, updated once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         count_ff  <= 3'd0;
         mask_ff   <= 1'b0;
         key_ff    <= 32'd0;
         remain_ff <= 64'd0;
         kpos_ff   <= 2'd0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         mask_ff   <= mask_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
         kpos_ff   <= kpos_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/websocket_frame_deframer_unit.sv */
// Top level of the WebSocket frame deframer: input register, parser, result
// register. Depends on wsfd_pkg and wsfd_parser.
//
//   channel | ports                                    | direction
//   --------+------------------------------------------+----------
//   req     | req_valid, req_stall, req_data_byte,     | in
//           | req_end_of_frame                         |
//   rsp     | rsp_valid, rsp_stall, rsp_payload_byte,  | out
//           | rsp_payload_last, rsp_status             |
//
// One byte per cycle sustained while rsp_stall is low; a byte is held in the
// input register, and its result is then registered in the result register.
// The parser state machine updates in the same cycle the byte leaves the
// input register. Synchronous reset puts the parser at the first header
// byte and empties both registers. A stalled result holds the result
// register and the input register; req_stall rises only when both are full.
`default_nettype none

module websocket_frame_deframer_unit
   import wsfd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_frame,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_payload_last,
   output logic [1:0]      rsp_status
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_data_ff;
   logic            in_eof_ff;
   logic            out_valid_ff;
   logic [7:0]      out_data_ff;
   logic            out_last_ff;
   status_type      out_status_ff;
   logic            out_free;
   logic            fire;
   logic            accept;
   wsfd_result_type result;

   // Pipeline control
   assign out_free    = !out_valid_ff || !rsp_stall;
   assign fire        = in_valid_ff && out_free;
   assign req_stall   = in_valid_ff && !out_free;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !fire);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_data_ff <= req_data_byte;
         in_eof_ff  <= req_end_of_frame;
      end
   end

   wsfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .data_byte    (in_data_ff),
      .end_of_frame (in_eof_ff),
      .result       (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire && result.valid;
      end
      if (fire && result.valid) begin
         out_data_ff   <= result.data;
         out_last_ff   <= result.last;
         out_status_ff <= result.status;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_data_ff;
   assign rsp_payload_last = out_last_ff;
   assign rsp_status       = out_status_ff;

`ifndef ASSERT_OFF
   // Non-data results carry a zero byte and close the frame
   a_nondata_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != ST_DATA |-> out_data_ff == 8'd0 && out_last_ff)
      else $error("non-data result with data or without last");

   // Input stalls only with both stages full and the result held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with a free stage");

   // A held result word does not change
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(out_data_ff)
         && $stable(out_last_ff) && $stable(out_status_ff))
      else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* tb/wsfd_result_checker.sv */
// Result checker for the WebSocket frame deframer: watches both channels,
// predicts each result word from the accepted frame bytes and compares.
// Depends on wsfd_pkg for the status codes and header constants.
module wsfd_result_checker
   import wsfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_frame,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_payload_byte,
   input  logic       rsp_payload_last,
   input  logic [1:0] rsp_status,
   output int         fail_count,
   output int         pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_HDR0, PH_LEN, PH_EXT16, PH_EXT64, PH_KEY, PH_PAYLOAD, PH_DROP
   } deframe_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      status_type status;
   } deframe_word_type;

   localparam deframe_word_type TRUNC_WORD = '{data: 8'h00, last: 1'b1, status: ST_ERROR};
   localparam deframe_word_type EMPTY_WORD = '{data: 8'h00, last: 1'b1, status: ST_EMPTY};

   // Predicted deframer state
   deframe_phase_type ph;
   logic [2:0]        hdr_count;
   logic              masked;
   logic [31:0]       mask_key;
   logic [63:0]       payload_left;
   logic [1:0]        key_pos;

   deframe_word_type  expected_words[$];
   deframe_word_type  want;
   deframe_word_type  fresh;

   // Frame ended too early: error word, back to the first header byte
   function automatic bit truncated(output deframe_word_type w);
      ph = PH_HDR0;
      w = TRUNC_WORD;
      return 1'b1;
   endfunction

   // Header and key complete: start payload or report an empty one
   function automatic bit header_done(input logic eof, output deframe_word_type w);
      key_pos = 2'd0;
      if (payload_left == 64'd0) begin
         ph = eof ? PH_HDR0 : PH_DROP;
         w = EMPTY_WORD;
         return 1'b1;
      end
      if (eof)
         return truncated(w);
      ph = PH_PAYLOAD;
      return 1'b0;
   endfunction

   // Length known: collect the key when masked
   function automatic bit length_known(input logic eof, output deframe_word_type w);
      if (masked) begin
         if (eof)
            return truncated(w);
         ph = PH_KEY;
         hdr_count = 3'd0;
         mask_key = 32'd0;
         return 1'b0;
      end
      return header_done(eof, w);
   endfunction

   // Advance the predicted state by one frame byte; 1 when a word results
   function automatic bit predict_deframe(input logic [7:0] b, input logic eof,
                                          output deframe_word_type w);
      logic [6:0] len7;
      logic [7:0] v;
      case (ph)
         PH_LEN: begin
            masked = (b & MASK_BIT) != 8'h00;
            len7 = 7'(b & LEN7_MASK);
            payload_left = 64'd0;
            hdr_count = 3'd0;
            if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
               if (eof)
                  return truncated(w);
               ph = (len7 == LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
               return 1'b0;
            end
            payload_left = 64'(len7);
            return length_known(eof, w);
         end
         PH_EXT16, PH_EXT64: begin
            payload_left = {payload_left[55:0], b};
            if (hdr_count == ((ph == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
               return length_known(eof, w);
            hdr_count = hdr_count + 3'd1;
            if (eof)
               return truncated(w);
            return 1'b0;
         end
         PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            if (hdr_count == KEY_LAST)
               return header_done(eof, w);
            hdr_count = hdr_count + 3'd1;
            if (eof)
               return truncated(w);
            return 1'b0;
         end
         PH_PAYLOAD: begin
            v = b;
            // first key byte sits in the top bits
            if (masked)
               v = v ^ 8'(mask_key >> (5'd24 - 5'd8 * 5'(key_pos)));
            key_pos = key_pos + 2'd1;
            payload_left = payload_left - 64'd1;
            if (payload_left == 64'd0) begin
               ph = eof ? PH_HDR0 : PH_DROP;
               w = '{data: v, last: 1'b1, status: ST_DATA};
               return 1'b1;
            end
            if (eof)
               return truncated(w);
            w = '{data: v, last: 1'b0, status: ST_DATA};
            return 1'b1;
         end
         PH_DROP: begin
            if (eof)
               ph = PH_HDR0;
            return 1'b0;
         end
         default: begin
            if (eof)
               return truncated(w);
            ph = PH_LEN;
            return 1'b0;
         end
      endcase
   endfunction

   // Compare accepted results first, then predict from the accepted byte
   always @(posedge clock) begin
      if (reset) begin
         ph = PH_HDR0;
         hdr_count = 3'd0;
         masked = 1'b0;
         mask_key = 32'd0;
         payload_left = 64'd0;
         key_pos = 2'd0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: byte %0h last %0d status %0d",
                      rsp_payload_byte, rsp_payload_last, rsp_status);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_payload_byte !== want.data) begin
                  $error("payload_byte expected %0h got %0h", want.data, rsp_payload_byte);
                  fail_count++;
               end
               if (rsp_payload_last !== want.last) begin
                  $error("payload_last expected %0d got %0d", want.last, rsp_payload_last);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            if (predict_deframe(req_data_byte, req_end_of_frame, fresh))
               expected_words = {expected_words, fresh};
      end
      pending_words = expected_words.size();
   end

endmodule

/* tb/tb_websocket_frame_deframer_unit.sv */
// Testbench top for websocket_frame_deframer_unit: clock, reset, frame
// stimulus with random idling and verdict. Depends on wsfd_pkg, the block
// and wsfd_result_checker.
module tb_websocket_frame_deframer_unit
   import wsfd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WORDS_PER_PHASE = 400;
   localparam int HOLD_CYCLES     = 64;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_frame = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_payload_last;
   logic [1:0] rsp_status;

   int         fail_count;
   int         pending_words;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         words_sent = 0;
   bit         hold_off_req = 1'b0;
   logic [7:0] frame_buf[$];

   websocket_frame_deframer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .rsp_status       (rsp_status)
   );

   wsfd_result_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_payload_last (rsp_payload_last),
      .rsp_status       (rsp_status),
      .fail_count       (fail_count),
      .pending_words    (pending_words)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   // Receiver: random stall, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   // Offer one word, with random idle cycles ahead of it; returns on a falling edge
   task automatic send_word(input logic [7:0] d, input logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_end_of_frame <= eof;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame_buf[i])
         send_word(frame_buf[i], i == frame_buf.size() - 1);
   endtask

   // Mostly well-formed frames; some cut short, some plain noise
   task automatic send_random_frame();
      int          pick;
      int          len_kind;
      int          n;
      bit          masked;
      bit          huge;
      logic [31:0] key;
      logic [63:0] len_val;
      logic [6:0]  len7;
      pick = $urandom_range(99);
      frame_buf = {};
      if (pick < 12) begin
         n = $urandom_range(1, 6);
         repeat (n) frame_buf = {frame_buf, 8'($urandom)};
      end else begin
         masked = 1'($urandom_range(1));
         key = $urandom;
         len_kind = $urandom_range(9);
         if ($urandom_range(9) == 0)
            len_val = 64'($urandom_range(0, 125));
         else
            len_val = 64'($urandom_range(0, 12));
         if (len_kind >= 6 && $urandom_range(7) == 0)
            len_val = (len_kind >= 8) ? {$urandom, $urandom} : 64'($urandom_range(0, 65535));
         len7 = (len_kind < 6) ? len_val[6:0] : (len_kind < 8) ? LEN7_EXT16 : LEN7_EXT64;
         frame_buf = {frame_buf, 8'($urandom)};
         frame_buf = {frame_buf, {masked, len7}};
         if (len_kind >= 6 && len_kind < 8)
            for (int i = 1; i >= 0; i--) frame_buf = {frame_buf, len_val[8*i +: 8]};
         if (len_kind >= 8)
            for (int i = 7; i >= 0; i--) frame_buf = {frame_buf, len_val[8*i +: 8]};
         if (masked)
            for (int i = 3; i >= 0; i--) frame_buf = {frame_buf, key[8*i +: 8]};
         // lengths too long to send end the frame inside the payload
         huge = len_val > 64'd200;
         n = huge ? $urandom_range(0, 8) : int'(len_val);
         repeat (n) frame_buf = {frame_buf, 8'($urandom)};
         if (!huge && $urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) frame_buf = {frame_buf, 8'($urandom)};
         if (pick < 27 && frame_buf.size() > 1)
            frame_buf = frame_buf[0 : $urandom_range(0, frame_buf.size() - 2)];
      end
      send_frame();
   endtask

   initial begin
      int target;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 26 : (p == 1) ? 88 : 0;
         recv_stall_pct = (p == 0) ? 88 : (p == 1) ? 26 : 0;
         if (p == 0) begin
            // one-byte frame
            frame_buf = {8'h81};
            send_frame();
            // unmasked empty payload
            frame_buf = {8'h82, 8'h00};
            send_frame();
            // ends right after a 16-bit length code
            frame_buf = {8'h82, 8'hFE};
            send_frame();
            // masked, two bytes, then a dropped trailing byte
            frame_buf = {8'h82, 8'h82, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00, 8'h7E};
            send_frame();
            // non-minimal 16-bit length of one
            frame_buf = {8'h00, 8'h7E, 8'h00, 8'h01, 8'hFF};
            send_frame();
            // 64-bit length with the top bit set, cut short
            frame_buf = {8'hFF, 8'h7F, 8'h80, 8'hFF, 8'h00};
            send_frame();
            // frame ends inside the payload
            frame_buf = {8'h81, 8'h03, 8'h00, 8'h55};
            send_frame();
         end
         // long receiver hold-off while the sender keeps going
         if (p == 2)
            hold_off_req = 1'b1;
         target = words_sent + WORDS_PER_PHASE;
         while (words_sent < target)
            send_random_frame();
      end
      req_valid <= 1'b0;

      wait (pending_words == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* filelist.f */
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/websocket_frame_deframer_unit.sv
tb/wsfd_result_checker.sv
tb/tb_websocket_frame_deframer_unit.sv
